[src/binarize_block_majority_filter_core_assert.svh]
// Assertion macros shared by the binarize block majority filter RTL.
// They check on the rising edge of i_clk and expect i_clk and i_rst_n in scope.
`ifndef BINARIZE_BLOCK_MAJORITY_FILTER_CORE_ASSERT_SVH
`define BINARIZE_BLOCK_MAJORITY_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BBMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define BBMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BBMF_ASSERT(lbl, prop, msg)

`define BBMF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[src/bbmf_pkg.sv]
package bbmf_pkg;

    localparam int LUMA_W     = 8;
    localparam int BLOCK_W    = 5;
    localparam int FRAME_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;

    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;
    localparam int TILE_IDX_W = 10;
    localparam int VALUE_W    = 8;

    localparam logic [LUMA_W-1:0]  LUMA_THRESHOLD_RST = 8'd120;
    localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST     = 5'd5;
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST    = 11'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST   = 11'd480;

    localparam logic [VALUE_W-1:0] TILE_BLACK = 8'd0;
    localparam logic [VALUE_W-1:0] TILE_WHITE = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LUMA_THRESHOLD = 2'd0,
        CFG_BLOCK_SIZE     = 2'd1,
        CFG_FRAME_WIDTH    = 2'd2,
        CFG_FRAME_HEIGHT   = 2'd3
    } t_cfg_idx;

endpackage

[src/bbmf_ram.sv]
module bbmf_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/binarize_block_majority_filter_core.sv]
// Channel      Direction  Transaction contents
// s_axis_*     in         one RGB pixel, tuser marks the first pixel of a frame
// m_axis_*     out        one finished tile vote, tlast marks the frame's last tile
// i_cfg_*      in         register write: threshold, block size, width, height
//
// One pixel is accepted per cycle unless stalled; a tile vote passes stage one and the
// output register after its last pixel. The per tile column count is read from the RAM
// at acceptance and written back as stage one advances; same-column hits are forwarded.
// A waiting output vote stalls the input only when the pixel behind it also votes.
// Reset is synchronous and restores the register defaults and the raster position;
// the count RAM is not cleared since every tile clears its column on its first pixel.
`include "binarize_block_majority_filter_core_assert.svh"

module binarize_block_majority_filter_core
    import bbmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [23:0]           s_axis_tdata,
    // frame_start [0]
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tile_row [9:0], tile_col [19:10], tile_value [27:20], zero [31:28]
    output logic [31:0]           m_axis_tdata,
    output logic                  m_axis_tlast,

    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int BW   = $clog2(MAX_BLOCK);
    localparam int BSW  = $clog2(MAX_BLOCK + 1);
    localparam int CNTW = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int RK   = ROW_W + $clog2(MAX_BLOCK);
    localparam int MW   = RK + 1;

    logic [LUMA_W-1:0]  r_luma_threshold;
    logic [BLOCK_W-1:0] r_block_size;
    logic [FRAME_W-1:0] r_frame_width;
    logic [FRAME_W-1:0] r_frame_height;

    logic [CW-1:0]      r_pixel_column, n_pixel_column;
    logic [ROW_W-1:0]   r_pixel_row, n_pixel_row;
    logic [BW-1:0]      r_col_in_tile, n_col_in_tile;
    logic [BW-1:0]      r_row_in_tile, n_row_in_tile;
    logic [CW-1:0]      r_tile_column, n_tile_column;

    logic               r_s1_valid;
    logic [CW-1:0]      r_s1_slot;
    logic               r_s1_white;
    logic               r_s1_first;
    logic               r_s1_emit;
    logic               r_s1_last;
    logic [ROW_W-1:0]   r_s1_row;

    logic               r_fwd_valid;
    logic [CW-1:0]      r_fwd_addr;
    logic [CNTW-1:0]    r_fwd_data;

    logic                  r_out_valid;
    logic [TILE_IDX_W-1:0] r_out_row;
    logic [TILE_IDX_W-1:0] r_out_col;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_last;

    logic [BSW-1:0]     w_blk;
    logic [WW-1:0]      w_wid;
    logic [FRAME_W-1:0] w_hgt;

    logic               w_accept;
    logic               w_s1_adv;
    logic               w_fs;
    logic [CW-1:0]      e_col;
    logic [ROW_W-1:0]   e_row;
    logic [BW-1:0]      e_ct;
    logic [BW-1:0]      e_rt;
    logic [CW-1:0]      e_tc;
    logic [9:0]         w_sum;
    logic               w_white;
    logic               w_emit;
    logic               w_last;

    logic [CNTW-1:0]    w_ram_q;
    logic [CNTW-1:0]    w_rd;
    logic [CNTW-1:0]    w_cnt;
    logic               w_vote;
    logic [MW-1:0]      w_recip [MAX_BLOCK + 1];
    logic [ROW_W+MW-1:0] w_prod;

    // Reciprocals for the tile row index: floor(row * m >> RK) equals row / b.
    assign w_recip[0] = '0;
    for (genvar gi = 1; gi <= MAX_BLOCK; gi++) begin : g_recip
        localparam int RECIP = ((1 << RK) + gi - 1) / gi;
        assign w_recip[gi] = MW'(RECIP);
    end

    always_comb begin
        if (r_block_size == '0) begin
            w_blk = BSW'(1);
        end else if (32'(r_block_size) > 32'(MAX_BLOCK)) begin
            w_blk = BSW'(MAX_BLOCK);
        end else begin
            w_blk = BSW'(r_block_size);
        end
        if (r_frame_width == '0) begin
            w_wid = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_wid = WW'(MAX_WIDTH);
        end else begin
            w_wid = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_hgt = FRAME_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            w_hgt = FRAME_W'(MAX_HEIGHT);
        end else begin
            w_hgt = r_frame_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_threshold <= LUMA_THRESHOLD_RST;
            r_block_size     <= BLOCK_SIZE_RST;
            r_frame_width    <= FRAME_WIDTH_RST;
            r_frame_height   <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_LUMA_THRESHOLD: r_luma_threshold <= i_cfg_data[LUMA_W-1:0];
                CFG_BLOCK_SIZE:     r_block_size     <= i_cfg_data[BLOCK_W-1:0];
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_data[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_data[FRAME_W-1:0];
            endcase
        end
    end

    assign w_s1_adv      = r_s1_valid && (!r_s1_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_fs  = s_axis_tuser;
    assign e_col = w_fs ? '0 : r_pixel_column;
    assign e_row = w_fs ? '0 : r_pixel_row;
    assign e_ct  = w_fs ? '0 : r_col_in_tile;
    assign e_rt  = w_fs ? '0 : r_row_in_tile;
    assign e_tc  = w_fs ? '0 : r_tile_column;

    // The channel mean exceeds the threshold exactly when the sum exceeds 3t + 2.
    assign w_sum   = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                   + 10'(s_axis_tdata[23:16]);
    assign w_white = 32'(w_sum) > (32'(r_luma_threshold) * 3 + 2);

    assign w_emit = (32'(e_ct) == 32'(w_blk) - 1) && (32'(e_rt) == 32'(w_blk) - 1)
                 && (32'(e_row) >= 32'(w_blk) - 1) && (32'(e_col) >= 32'(w_blk) - 1)
                 && (32'(e_row) + 1 < 32'(w_hgt)) && (32'(e_col) + 1 < 32'(w_wid));
    assign w_last = (32'(e_row) + 1 + 32'(w_blk) >= 32'(w_hgt))
                 && (32'(e_col) + 1 + 32'(w_blk) >= 32'(w_wid));

    always_comb begin
        logic [CW:0]    c_inc;
        logic [BW:0]    ct_inc;
        logic [CW:0]    tc_inc;
        logic [ROW_W:0] r_inc;
        logic [BW:0]    rt_inc;
        c_inc  = {1'b0, e_col} + 1'b1;
        ct_inc = {1'b0, e_ct} + 1'b1;
        tc_inc = {1'b0, e_tc};
        r_inc  = {1'b0, e_row};
        rt_inc = {1'b0, e_rt};
        if (32'(ct_inc) >= 32'(w_blk)) begin
            ct_inc = '0;
            tc_inc = tc_inc + 1'b1;
        end
        if (32'(c_inc) >= 32'(w_wid)) begin
            c_inc  = '0;
            ct_inc = '0;
            tc_inc = '0;
            r_inc  = r_inc + 1'b1;
            rt_inc = rt_inc + 1'b1;
            if (32'(rt_inc) >= 32'(w_blk)) begin
                rt_inc = '0;
            end
            if (32'(r_inc) >= 32'(w_hgt)) begin
                r_inc  = '0;
                rt_inc = '0;
            end
        end
        if (32'(tc_inc) >= 32'(MAX_WIDTH)) begin
            tc_inc = '0;
        end
        n_pixel_column = c_inc[CW-1:0];
        n_col_in_tile  = ct_inc[BW-1:0];
        n_tile_column  = tc_inc[CW-1:0];
        n_pixel_row    = r_inc[ROW_W-1:0];
        n_row_in_tile  = rt_inc[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_column <= '0;
            r_pixel_row    <= '0;
            r_col_in_tile  <= '0;
            r_row_in_tile  <= '0;
            r_tile_column  <= '0;
        end else if (w_accept) begin
            r_pixel_column <= n_pixel_column;
            r_pixel_row    <= n_pixel_row;
            r_col_in_tile  <= n_col_in_tile;
            r_row_in_tile  <= n_row_in_tile;
            r_tile_column  <= n_tile_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_slot  <= e_tc;
            r_s1_white <= w_white;
            r_s1_first <= (e_ct == '0) && (e_rt == '0);
            r_s1_emit  <= w_emit;
            r_s1_last  <= w_last;
            r_s1_row   <= e_row;
        end
    end

    bbmf_ram #(
        .WIDTH (CNTW),
        .DEPTH (MAX_WIDTH)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_slot),
        .i_wdata (w_cnt),
        .i_re    (w_accept),
        .i_raddr (e_tc),
        .o_rdata (w_ram_q)
    );

    assign w_rd   = (r_fwd_valid && (r_fwd_addr == r_s1_slot)) ? r_fwd_data : w_ram_q;
    assign w_cnt  = r_s1_first ? CNTW'(r_s1_white) : w_rd + CNTW'(r_s1_white);
    assign w_vote = (32'(w_cnt) << 1) > (32'(w_blk) * 32'(w_blk));
    assign w_prod = (ROW_W + MW)'(r_s1_row) * (ROW_W + MW)'(w_recip[w_blk]);

    // A write-back that lands on the edge of the next read is seen through this bypass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_s1_adv || w_accept) begin
            r_fwd_valid <= w_s1_adv && w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_fwd_addr <= r_s1_slot;
            r_fwd_data <= w_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && r_s1_emit) begin
            r_out_row   <= w_prod[RK +: TILE_IDX_W];
            r_out_col   <= TILE_IDX_W'(r_s1_slot);
            r_out_value <= w_vote ? TILE_WHITE : TILE_BLACK;
            r_out_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_value, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

    `BBMF_ASSERT(a_fwd_needs_item, r_fwd_valid |-> r_s1_valid, "bypass armed without an item")
    `BBMF_ASSERT(a_out_from_vote, $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_emit), "vote without a tile end")
    `BBMF_ASSERT(a_vote_code, r_out_valid |-> (r_out_value == TILE_BLACK || r_out_value == TILE_WHITE), "bad vote code")
    `BBMF_ASSERT_ALWAYS(a_reset_flush, !i_rst_n |=> (!r_out_valid && !r_s1_valid), "pipeline not flushed by reset")

endmodule
